@@ design/mnb_pkg.sv @@
package mnb_pkg;
	localparam int NUM_CLASSES   = 16;
	localparam int NUM_FEATURES  = 256;
	localparam int COUNT_WIDTH   = 32;
	localparam int LOG_FRAC_BITS = 16;
	localparam int TOTAL_WIDTH   = COUNT_WIDTH + 8;
	localparam int SCORE_WIDTH   = 48;
	localparam int CLS_W         = 4;
	localparam int FEAT_W        = 8;
	localparam int ADDR_W        = CLS_W + FEAT_W;
	localparam int DEPTH         = NUM_CLASSES * NUM_FEATURES;
	localparam int LOGV_W        = 7 + LOG_FRAC_BITS;

	localparam logic [1:0] CMD_TRAIN   = 2'd0;
	localparam logic [1:0] CMD_PREDICT = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic CFG_CLASSES  = 1'b0;
	localparam logic CFG_FEATURES = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  sample_class;
		logic [7:0]  feature_index;
		logic [15:0] feature_value;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         predicted_class;
		logic signed [47:0] best_score;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_TR_RD, ST_TR_WR, ST_PR_RD, ST_PR_LD, ST_PR_NUM,
		ST_PR_LOGN, ST_PR_LOGD, ST_PR_MUL, ST_PR_ACC, ST_PO_LD, ST_PO_NUM,
		ST_PO_LOGN, ST_PO_LOGD, ST_PO_CMP, ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_wr;     // write zero at clear counter
		logic clr_regs;   // zero small stores
		logic tr_rd;      // read count entry
		logic tr_wr;      // write updated entry and totals
		logic pr_rd;      // read entry of class counter
		logic ld;         // load log operands
		logic log_start;
		logic log_sel_den;
		logic log_prior;
		logic mul;
		logic acc;
		logic cmp;
		logic cls_first;
		logic cls_next;
		logic clr_scores;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic log_done;
		logic cls_last;
	} stat_t;
endpackage

@@ design/mnb_ram.sv @@
module mnb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ design/mnb_log2.sv @@
module mnb_log2 import mnb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [47:0]       x,
	output logic              done,
	output logic [LOGV_W-1:0] result
);
	logic [32:0] m_q;
	logic [5:0]  p_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [5:0]  p;
	logic [47:0] xs;
	logic [65:0] sq;
	logic [34:0] sqs;

	always_comb begin
		p = '0;
		for (int i = 1; i < 48; i++) if (x[i]) p = 6'(i);
		xs = (p >= 6'd31) ? (x >> (p - 6'd31)) : (x << (6'd31 - p));
		if (x == '0) xs = 48'h8000_0000;
		sq  = m_q * m_q;
		sqs = sq[65:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(LOG_FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= {1'b0, xs[31:0]};
			p_q    <= p;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sqs[32]) begin
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
				m_q    <= sqs[33:1];
			end else begin
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
				m_q    <= sqs[32:0];
			end
		end
	end

	assign result = {1'b0, p_q, frac_q};
endmodule

@@ design/mnb_datapath.sv @@
module mnb_datapath import mnb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  logic      item_load,
	input  logic [4:0] nc,
	input  logic [8:0] nf,
	input  cmd_t      cmd,
	output stat_t     stat,
	output in_item_t  item_q,
	output out_item_t result
);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
	localparam logic [TOTAL_WIDTH-1:0] TMAX = '1;
	localparam logic signed [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

	logic [COUNT_WIDTH-1:0] samp_q [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] tsamp_q;
	logic [TOTAL_WIDTH-1:0] tot_q [NUM_CLASSES];
	logic signed [SCORE_WIDTH-1:0] score_q [NUM_CLASSES];
	logic [ADDR_W:0] clr_q;
	logic [CLS_W-1:0] c_q;
	logic [COUNT_WIDTH-1:0] rdata;
	logic ram_we;
	logic feat_in;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [COUNT_WIDTH-1:0] wdata, cnt_new;
	logic [TOTAL_WIDTH-1:0] tot_new;
	logic [COUNT_WIDTH:0] csum;
	logic [TOTAL_WIDTH:0] tsum;
	logic [47:0] lx;
	logic [LOGV_W-1:0] lres, ln_q;
	logic signed [LOGV_W:0] ratio;
	logic signed [LOGV_W+17:0] term_s1;
	logic signed [SCORE_WIDTH+1:0] sum;
	logic signed [SCORE_WIDTH-1:0] sat_sum, best_q;
	logic [CLS_W-1:0] best_c_q;
	logic [COUNT_WIDTH:0] cnt1_q;
	logic [TOTAL_WIDTH:0] den_q;
	logic ldone;

	mnb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	mnb_log2 u_log (.clk(clk), .arst_n(arst_n), .start(cmd.log_start), .x(lx),
		.done(ldone), .result(lres));

	always_comb begin
		feat_in = {1'b0, item_q.feature_index} < nf;
		csum = {1'b0, rdata} + {{COUNT_WIDTH-15{1'b0}}, item_q.feature_value};
		cnt_new = csum[COUNT_WIDTH] ? CMAX : csum[COUNT_WIDTH-1:0];
		tsum = {1'b0, tot_q[item_q.sample_class]}
			+ {{TOTAL_WIDTH-15{1'b0}}, item_q.feature_value};
		tot_new = tsum[TOTAL_WIDTH] ? TMAX : tsum[TOTAL_WIDTH-1:0];
		ram_we = cmd.clr_wr | (cmd.tr_wr & feat_in);
		waddr = cmd.clr_wr ? clr_q[ADDR_W-1:0] : {item_q.sample_class, item_q.feature_index};
		wdata = cmd.clr_wr ? '0 : cnt_new;
		raddr = cmd.pr_rd ? {c_q, item_q.feature_index}
			: {item_q.sample_class, item_q.feature_index};
		if (cmd.log_sel_den) lx = 48'(den_q);
		else lx = 48'(cnt1_q);
		ratio = $signed({1'b0, ln_q}) - $signed({1'b0, lres});
		sum = 50'(score_q[c_q]) + 50'(cmd.log_prior ? 50'(ratio) : 50'(term_s1));
		sat_sum = (sum < 50'(SMIN)) ? SMIN : sum[SCORE_WIDTH-1:0];
		stat.clr_done = clr_q[ADDR_W];
		stat.log_done = ldone;
		stat.cls_last = ({1'b0, c_q} == nc - 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			tsamp_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				samp_q[i] <= '0; tot_q[i] <= '0; score_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_regs) begin
				clr_q <= '0;
				tsamp_q <= '0;
				for (int i = 0; i < NUM_CLASSES; i++) begin
					samp_q[i] <= '0; tot_q[i] <= '0; score_q[i] <= '0;
				end
			end else if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.tr_wr) begin
				if (feat_in) tot_q[item_q.sample_class] <= tot_new;
				if (item_q.last) begin
					if (samp_q[item_q.sample_class] != CMAX)
						samp_q[item_q.sample_class] <= samp_q[item_q.sample_class] + 1'b1;
					if (tsamp_q != CMAX) tsamp_q <= tsamp_q + 1'b1;
				end
			end
			if (cmd.acc) score_q[c_q] <= sat_sum;
			if (cmd.clr_scores)
				for (int i = 0; i < NUM_CLASSES; i++) score_q[i] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) item_q <= item;
		if (cmd.cls_first) c_q <= '0;
		else if (cmd.cls_next) c_q <= c_q + 1'b1;
		// Operands are held here so the log2 unit sees them straight from a register.
		if (cmd.ld) begin
			if (cmd.log_prior) begin
				cnt1_q <= {1'b0, samp_q[c_q]} + 1'b1;
				den_q <= (TOTAL_WIDTH+1)'(tsamp_q) + (TOTAL_WIDTH+1)'(nc);
			end else begin
				cnt1_q <= {1'b0, rdata} + 1'b1;
				den_q <= {1'b0, tot_q[c_q]} + (TOTAL_WIDTH+1)'(nf);
			end
		end
		if (cmd.log_start && cmd.log_sel_den) ln_q <= lres;
		if (cmd.mul) term_s1 <= $signed({1'b0, item_q.feature_value}) * ratio;
		if (cmd.cmp && (c_q == '0 || sat_sum > best_q)) begin
			best_q <= sat_sum;
			best_c_q <= c_q;
		end
	end

	assign result.predicted_class = best_c_q;
	assign result.best_score = best_q;
endmodule

@@ design/mnb_ctrl.sv @@
module mnb_ctrl import mnb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     item_load,
	input  in_item_t item,
	input  in_item_t item_q,
	input  logic [4:0] nc,
	input  logic [8:0] nf,
	input  stat_t    stat,
	output cmd_t     cmd,
	output logic     out_valid,
	input  logic     out_ready
);
	state_t st_q, st_d;
	logic feat_ok;

	assign feat_ok = {1'b0, item_q.feature_index} < nf;
	assign in_ready = (st_q == ST_IDLE);
	assign item_load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (stat.clr_done) st_d = ST_IDLE;
			ST_IDLE: if (item_load) begin
				case (item.command)
					CMD_TRAIN:   st_d = ({1'b0, item.sample_class} < nc) ? ST_TR_RD : ST_IDLE;
					CMD_PREDICT: st_d = ST_PR_RD;
					CMD_CLEAR:   st_d = ST_CLEAR;
					default:     st_d = ST_IDLE;
				endcase
			end
			ST_TR_RD: st_d = ST_TR_WR;
			ST_TR_WR: st_d = ST_IDLE;
			ST_PR_RD: st_d = !feat_ok ? (item_q.last ? ST_PO_LD : ST_IDLE) : ST_PR_LD;
			ST_PR_LD: st_d = ST_PR_NUM;
			ST_PR_NUM: st_d = ST_PR_LOGN;
			ST_PR_LOGN: if (stat.log_done) st_d = ST_PR_LOGD;
			ST_PR_LOGD: if (stat.log_done) st_d = ST_PR_MUL;
			ST_PR_MUL: st_d = ST_PR_ACC;
			ST_PR_ACC: st_d = stat.cls_last ? (item_q.last ? ST_PO_LD : ST_IDLE) : ST_PR_RD;
			ST_PO_LD: st_d = ST_PO_NUM;
			ST_PO_NUM: st_d = ST_PO_LOGN;
			ST_PO_LOGN: if (stat.log_done) st_d = ST_PO_LOGD;
			ST_PO_LOGD: if (stat.log_done) st_d = ST_PO_CMP;
			ST_PO_CMP: st_d = stat.cls_last ? ST_OUT : ST_PO_LD;
			ST_OUT: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		out_valid = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				cmd.clr_wr = !stat.clr_done;
				cmd.clr_regs = stat.clr_done;
			end
			ST_IDLE: cmd.cls_first = 1'b1;
			ST_TR_RD: cmd.tr_rd = 1'b1;
			ST_TR_WR: cmd.tr_wr = feat_ok || item_q.last;
			ST_PR_RD: begin
				cmd.pr_rd = 1'b1;
				cmd.cls_first = !feat_ok;
			end
			ST_PR_LD: cmd.ld = 1'b1;
			ST_PR_NUM: cmd.log_start = 1'b1;
			ST_PR_LOGN: begin
				cmd.log_start = stat.log_done;
				cmd.log_sel_den = stat.log_done;
			end
			ST_PR_LOGD: cmd = '0;
			ST_PR_MUL: cmd.mul = 1'b1;
			ST_PR_ACC: begin
				cmd.acc = 1'b1;
				cmd.cls_next = !stat.cls_last;
				cmd.cls_first = stat.cls_last;
			end
			ST_PO_LD: begin
				cmd.log_prior = 1'b1;
				cmd.ld = 1'b1;
			end
			ST_PO_NUM: begin
				cmd.log_prior = 1'b1;
				cmd.log_start = 1'b1;
			end
			ST_PO_LOGN: begin
				cmd.log_prior = 1'b1;
				cmd.log_start = stat.log_done;
				cmd.log_sel_den = stat.log_done;
			end
			ST_PO_LOGD: cmd.log_prior = 1'b1;
			ST_PO_CMP: begin
				cmd.log_prior = 1'b1;
				cmd.cmp = 1'b1;
				cmd.cls_next = !stat.cls_last;
				cmd.clr_scores = stat.cls_last;
			end
			ST_OUT: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule

@@ design/multinomial_naive_bayes_classifier_unit.sv @@
// Flow: an in-range train item passes a read and a write state; an in-range predict item
// takes a read, a load, two log2 passes, a multiply and an accumulate per active class,
// and the last element of a sample adds a prior pass per class; the result then waits
// in the output state until taken. Throughput: one item at a time, two passes of the
// shared log2 unit per class. Reset: asynchronous active low; after reset a clearing
// pass zeroes the count memory before any item is taken, and a clear command repeats it.
module multinomial_naive_bayes_classifier_unit import mnb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [8:0] cfg_data
);
	logic [4:0] ac_q;
	logic [8:0] af_q;
	logic [4:0] nc;
	logic [8:0] nf;
	cmd_t cmd;
	stat_t stat;
	in_item_t item_q;
	logic item_load;

	// Hold the configuration; clamp to the supported range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q <= 5'd16;
			af_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLASSES:  ac_q <= cfg_data[4:0];
				CFG_FEATURES: af_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nc = (ac_q == '0) ? 5'd1 : (ac_q > 5'(NUM_CLASSES)) ? 5'(NUM_CLASSES) : ac_q;
	assign nf = (af_q == '0) ? 9'd1 : (af_q > 9'(NUM_FEATURES)) ? 9'(NUM_FEATURES) : af_q;

	mnb_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.item_load(item_load), .item(in_data), .item_q(item_q), .nc(nc), .nf(nf),
		.stat(stat), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready));

	mnb_datapath u_dp (.clk(clk), .arst_n(arst_n), .item(in_data), .item_load(item_load),
		.nc(nc), .nf(nf), .cmd(cmd), .stat(stat), .item_q(item_q), .result(out_data));
endmodule

@@ test/tb_top.sv @@
module tb_top;
	import mnb_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_index = CFG_CLASSES;
	logic [8:0] cfg_data = '0;

	multinomial_naive_bayes_classifier_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the classifier statistics, used to predict each decision.
	logic [8:0]              nb_classes_reg, nb_features_reg;
	logic [COUNT_WIDTH-1:0]  nb_samples [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0]  nb_total_samples;
	logic [COUNT_WIDTH-1:0]  nb_counts [DEPTH];
	logic [TOTAL_WIDTH-1:0]  nb_totals [NUM_CLASSES];
	logic signed [63:0]      nb_scores [NUM_CLASSES];

	in_item_t  pending_items[$];
	out_item_t expected_decisions[$];
	int        fails = 0;
	int        send_idle_pct = 0, recv_stall_pct = 0;
	bit        hold_off = 1'b0;
	bit        hold_go = 1'b0;
	int        hold_left = 0;
	longint    cycle_count = 0;

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		if (a >= lim || b > lim - a)
			return lim;
		return a + b;
	endfunction

	function automatic logic signed [63:0] clamp_score(logic signed [63:0] s);
		logic signed [63:0] floor_v;
		floor_v = -(64'sd1 <<< 47);
		return (s < floor_v) ? floor_v : s;
	endfunction

	// Q.16 log2 by repeated squaring of a normalized mantissa.
	function automatic logic signed [63:0] log2_q(logic [63:0] x);
		int unsigned p;
		logic [127:0] m;
		logic [63:0] frac;
		p = 0;
		frac = 0;
		if (x == 0)
			x = 1;
		while (p < 63 && (x >> (p + 1)) != 0)
			p++;
		m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
		for (int i = 0; i < LOG_FRAC_BITS; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (128'd1 << 32)) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return signed'((64'(p) << LOG_FRAC_BITS) | frac);
	endfunction

	function automatic int eff_classes();
		if (nb_classes_reg[4:0] < 1) return 1;
		if (nb_classes_reg[4:0] > NUM_CLASSES) return NUM_CLASSES;
		return nb_classes_reg[4:0];
	endfunction

	function automatic int eff_features();
		if (nb_features_reg < 1) return 1;
		if (nb_features_reg > NUM_FEATURES) return NUM_FEATURES;
		return nb_features_reg;
	endfunction

	task automatic wipe_stats();
		foreach (nb_samples[i]) nb_samples[i] = '0;
		foreach (nb_counts[i]) nb_counts[i] = '0;
		foreach (nb_totals[i]) nb_totals[i] = '0;
		foreach (nb_scores[i]) nb_scores[i] = 0;
		nb_total_samples = '0;
	endtask

	// Advance the shadow on one accepted item; queue a decision if one is due.
	task automatic classify_item(in_item_t it);
		int nc, nf, k, best;
		logic signed [63:0] term, s, best_s;
		logic [63:0] num, den;
		out_item_t d;
		nc = eff_classes();
		nf = eff_features();
		if (it.command == CMD_CLEAR) begin
			wipe_stats();
			return;
		end
		if (it.command == CMD_TRAIN) begin
			if (it.sample_class >= nc)
				return;
			if (it.feature_index < nf) begin
				k = it.sample_class * NUM_FEATURES + it.feature_index;
				nb_counts[k] = sat_sum(nb_counts[k], it.feature_value, 64'hFFFF_FFFF);
				nb_totals[it.sample_class] = sat_sum(nb_totals[it.sample_class],
					it.feature_value, 64'hFF_FFFF_FFFF);
			end
			if (it.last) begin
				nb_samples[it.sample_class] = sat_sum(nb_samples[it.sample_class], 1,
					64'hFFFF_FFFF);
				nb_total_samples = sat_sum(nb_total_samples, 1, 64'hFFFF_FFFF);
			end
			return;
		end
		if (it.command != CMD_PREDICT)
			return;
		if (it.feature_index < nf) begin
			for (int c = 0; c < nc; c++) begin
				num = 64'(nb_counts[c * NUM_FEATURES + it.feature_index]) + 1;
				den = 64'(nb_totals[c]) + nf;
				term = signed'(64'(it.feature_value)) * (log2_q(num) - log2_q(den));
				nb_scores[c] = clamp_score(nb_scores[c] + term);
			end
		end
		if (!it.last)
			return;
		best = 0;
		best_s = 0;
		for (int c = 0; c < nc; c++) begin
			s = clamp_score(nb_scores[c] + log2_q(64'(nb_samples[c]) + 1)
				- log2_q(64'(nb_total_samples) + nc));
			if (c == 0 || s > best_s) begin
				best_s = s;
				best = c;
			end
		end
		foreach (nb_scores[i]) nb_scores[i] = 0;
		d.predicted_class = best[3:0];
		d.best_score = best_s[47:0];
		expected_decisions.push_back(d);
	endtask

	// Driver: present queued items, hold each until accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				classify_item(in_data);
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check decisions against the oldest expectation, stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_decisions.size() == 0) begin
					$display("%0t: unexpected decision class %0d score %0d", $time,
						out_data.predicted_class, out_data.best_score);
					fails++;
				end else begin
					out_item_t e;
					e = expected_decisions.pop_front();
					if (e.predicted_class !== out_data.predicted_class) begin
						$display("%0t: class expected %0d actual %0d", $time,
							e.predicted_class, out_data.predicted_class);
						fails++;
					end
					if (e.best_score !== out_data.best_score) begin
						$display("%0t: score expected %0d actual %0d", $time,
							e.best_score, out_data.best_score);
						fails++;
					end
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Receiver hold-off: once requested, block the output until hold_left counts down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				hold_off <= 1'b0;
		end else if (hold_go && !hold_off) begin
			hold_off <= 1'b1;
			hold_left <= 3000;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [1:0] cmd, int cls, int feat, int val, bit lst);
		in_item_t it;
		it.command = cmd;
		it.sample_class = cls[3:0];
		it.feature_index = feat[7:0];
		it.feature_value = val[15:0];
		it.last = lst;
		return it;
	endfunction

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_decisions.size() > 0)
			@(posedge clk);
		// train and clear items leave work behind
		repeat (4400) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CLASSES)
			nb_classes_reg = val[4:0];
		else
			nb_features_reg = val[8:0];
	endtask

	// Queue one well-formed sample: a few elements, last on the final one.
	task automatic queue_sample(logic [1:0] cmd, int n_elems, int feat_lim);
		int cls, fmax;
		cls = $urandom_range(eff_classes() - 1);
		fmax = (feat_lim > 255) ? 255 : feat_lim;
		for (int j = 0; j < n_elems; j++)
			pending_items.push_back(make_item(cmd, cls, $urandom_range(fmax),
				($urandom_range(9) == 0) ? $urandom : $urandom_range(20),
				j == n_elems - 1));
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(99);
			if (r < 45)
				queue_sample(CMD_TRAIN, $urandom_range(1, 3), eff_features() - 1);
			else if (r < 85)
				queue_sample(CMD_PREDICT, $urandom_range(1, 2), eff_features() - 1);
			else if (r < 97)
				pending_items.push_back(make_item($urandom_range(1) ? CMD_TRAIN : CMD_PREDICT,
					$urandom, $urandom, $urandom, 1'($urandom)));
			else if (r < 98)
				pending_items.push_back(make_item(CMD_CLEAR, $urandom, $urandom, $urandom, 1'b0));
			else
				pending_items.push_back(make_item(2'd3, $urandom, $urandom, $urandom, 1'b1));
		end
	endtask

	initial begin
		nb_classes_reg = 16;
		nb_features_reg = 256;
		wipe_stats();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4200) @(posedge clk);

		// Directed: extremes of every field, each command, out-of-range cases.
		pending_items.push_back(make_item(CMD_PREDICT, 0, 0, 0, 1'b1));
		pending_items.push_back(make_item(CMD_TRAIN, 15, 255, 65535, 1'b1));
		pending_items.push_back(make_item(CMD_TRAIN, 0, 0, 65535, 1'b0));
		pending_items.push_back(make_item(CMD_TRAIN, 3, 7, 1, 1'b1));
		pending_items.push_back(make_item(CMD_PREDICT, 9, 255, 65535, 1'b0));
		pending_items.push_back(make_item(CMD_PREDICT, 0, 7, 3, 1'b1));
		pending_items.push_back(make_item(2'd3, 15, 255, 65535, 1'b1));
		pending_items.push_back(make_item(CMD_PREDICT, 0, 0, 65535, 1'b1));
		pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 0, 1'b1));
		pending_items.push_back(make_item(CMD_PREDICT, 15, 128, 1, 1'b1));
		drain();

		// Narrow config: class and feature out of range are exercised.
		write_reg(CFG_CLASSES, 2);
		write_reg(CFG_FEATURES, 4);
		pending_items.push_back(make_item(CMD_TRAIN, 5, 1, 9, 1'b1));
		pending_items.push_back(make_item(CMD_TRAIN, 1, 200, 9, 1'b1));
		pending_items.push_back(make_item(CMD_TRAIN, 0, 2, 30, 1'b1));
		pending_items.push_back(make_item(CMD_PREDICT, 0, 100, 5, 1'b0));
		pending_items.push_back(make_item(CMD_PREDICT, 0, 2, 4, 1'b1));
		random_phase(40);
		drain();

		// Extremes: one class and one feature; zero values are clamped to one, too-large ones to the maximum.
		write_reg(CFG_CLASSES, 1);
		write_reg(CFG_FEATURES, 1);
		random_phase(20);
		drain();
		write_reg(CFG_CLASSES, 0);
		write_reg(CFG_FEATURES, 0);
		random_phase(15);
		drain();
		write_reg(CFG_CLASSES, 31);
		write_reg(CFG_FEATURES, 511);
		random_phase(15);
		drain();

		write_reg(CFG_CLASSES, 4);
		write_reg(CFG_FEATURES, 16);
		send_idle_pct = 47;
		random_phase(50);
		drain();

		// Long receiver hold-off while the sender keeps offering.
		send_idle_pct = 0;
		random_phase(30);
		hold_go = 1'b1;
		wait (hold_off);
		hold_go = 1'b0;
		wait (!hold_off);
		drain();

		write_reg(CFG_CLASSES, 16);
		write_reg(CFG_FEATURES, 256);
		recv_stall_pct = 47;
		random_phase(50);
		drain();
		send_idle_pct = 16;
		recv_stall_pct = 16;
		random_phase(75);
		drain();

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
